// ----- hdl/ctl_pkg.sv -----
`timescale 1ns / 1ps
// Package for the configuration text lexer: payload structs, lexer modes,
// token class and error codes, register indexes and character class functions.
// No dependencies.
package ctl_pkg;

    // Input item: one text byte and its end-of-text flag.
    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_text;
    } t_in;

    // Result item: one token byte or a marker.
    typedef struct packed {
        logic [7:0]  out_char;
        logic [2:0]  token_class;
        logic        token_start;
        logic [15:0] line_number;
        logic [1:0]  error_code;
        logic        last_result;
    } t_out;

    typedef enum logic [8:0] {
        M_IDLE   = 9'b000000001,
        M_SLASH  = 9'b000000010,
        M_LCOMM  = 9'b000000100,
        M_BLOCK  = 9'b000001000,
        M_BSTAR  = 9'b000010000,
        M_STRING = 9'b000100000,
        M_WORD   = 9'b001000000,
        M_NUMBER = 9'b010000000,
        M_NAME   = 9'b100000000
    } t_mode;

    localparam logic [2:0] CLS_STRING = 3'd0;
    localparam logic [2:0] CLS_WORD   = 3'd1;
    localparam logic [2:0] CLS_NUMBER = 3'd2;
    localparam logic [2:0] CLS_PUNCT  = 3'd3;
    localparam logic [2:0] CLS_NAME   = 3'd4;
    localparam logic [2:0] CLS_MARKER = 3'd5;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_STRING = 2'd1;
    localparam logic [1:0] ERR_BYTE   = 2'd2;

    // Configuration register indexes.
    localparam int CFG_C_COMMENTS    = 0;
    localparam int CFG_HASH_COMMENTS = 1;
    localparam int CFG_STRINGS       = 2;
    localparam int CFG_WHOLE_WORD    = 3;
    localparam int CFG_NUMBERS       = 4;
    localparam int CFG_PUNCT         = 5;
    localparam int CFG_NAMES         = 6;
    localparam int CFG_COUNT         = 7;
    localparam int CFG_IDX_BITS      = 3;
    localparam logic [CFG_COUNT-1:0] CFG_RESET = 7'b1110101;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_UNDER   = 8'h5F;

    // Result queue between the lexing stage and the output port.
    localparam int QDEPTH     = 8;
    localparam int QPTR_BITS  = 3;
    localparam int QCNT_BITS  = 4;
    localparam int MAX_RES    = 3;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_name(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A))
            || ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_UNDER);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        logic r;
        r = 1'b0;
        case (c) inside
            8'h2B, 8'h2D, 8'h3D, 8'h5B, 8'h5D, 8'h7B, 8'h7D,
            8'h28, 8'h29, 8'h3A, 8'h3B, 8'h2C, 8'h40, 8'h2A: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/config_text_lexer_unit.sv -----
`timescale 1ns / 1ps
// Configuration text lexer, top level: input register, lexing stage, result queue.
// Depends on ctl_pkg.
//
//  channel   direction  handshake                     payload
//  in        input      i_in_valid / o_in_ready       i_in_data  (t_in)
//  out       output     o_out_valid / i_out_ready     o_out_data (t_out)
//  cfg       input      i_cfg_we (no wait)            i_cfg_idx, i_cfg_data
//
// An item is registered on acceptance and lexed in the next cycle; its zero to
// three results are then written into an eight-entry queue.
// A new item is taken every cycle while the queue holds at most two results, so
// the sustained rate is one item per cycle when each item yields at most one
// result; the output drains one result per cycle while i_out_ready is high.
// Reset is synchronous and active low; it restores the register defaults,
// empties the queue and sets the line count to one.
module config_text_lexer_unit
    import ctl_pkg::*;
#(
    parameter int LINE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in                     i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out                    o_out_data,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic                    i_cfg_data
);

    typedef struct packed {
        logic       emit;
        logic [7:0] ch;
        logic [2:0] cls;
        logic       start;
        logic [1:0] err;
        logic       nl;
        t_mode      mode;
    } t_idle;

    logic [CFG_COUNT-1:0] r_cfg;
    t_in                  r_in;
    logic                 r_in_valid;
    t_mode                r_mode, n_mode;
    logic [LINE_BITS-1:0] r_line, n_line;

    t_out                 r_q [QDEPTH];
    logic [QPTR_BITS-1:0] r_wp, r_rp;
    logic [QCNT_BITS-1:0] r_cnt;

    t_out                 slot [MAX_RES];
    logic [1:0]           n_res;

    logic                 in_acc, out_acc;

    function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] l);
        return (l == '1) ? l : l + LINE_BITS'(1);
    endfunction

    function automatic logic [15:0] line_out(input logic [LINE_BITS-1:0] l);
        logic [LINE_BITS+15:0] ext;
        ext = {16'b0, l};
        return ext[15:0];
    endfunction

    // Lexing of a byte seen between tokens.
    function automatic t_idle lex_idle(input logic [7:0] c, input logic comments,
                                       input logic [CFG_COUNT-1:0] cfg);
        t_idle r;
        r = '{emit: 1'b0, ch: c, cls: CLS_MARKER, start: 1'b1, err: ERR_NONE,
              nl: 1'b0, mode: M_IDLE};
        if (c <= CH_SPACE) begin
            r.nl = (c == CH_NL);
        end else if (comments && cfg[CFG_C_COMMENTS] && c == CH_SLASH) begin
            r.mode = M_SLASH;
        end else if (comments && cfg[CFG_HASH_COMMENTS] && c == CH_HASH) begin
            r.mode = M_LCOMM;
        end else begin
            r.emit = 1'b1;
            if (cfg[CFG_STRINGS] && c == CH_QUOTE) begin
                r.cls  = CLS_STRING;
                r.mode = M_STRING;
            end else if (cfg[CFG_WHOLE_WORD]) begin
                r.cls  = CLS_WORD;
                r.mode = M_WORD;
            end else if (cfg[CFG_NUMBERS] && (is_digit(c) || c == CH_MINUS)) begin
                r.cls  = CLS_NUMBER;
                r.mode = M_NUMBER;
            end else if (cfg[CFG_PUNCT] && is_punct(c)) begin
                r.cls  = CLS_PUNCT;
            end else if (cfg[CFG_NAMES] && is_name(c)) begin
                r.cls  = CLS_NAME;
                r.mode = M_NAME;
            end else begin
                r.ch    = CH_NUL;
                r.start = 1'b0;
                r.err   = ERR_BYTE;
            end
        end
        return r;
    endfunction

    function automatic t_out mk(input logic [7:0] ch, input logic [2:0] cls,
                                input logic start, input logic [1:0] err,
                                input logic last, input logic [LINE_BITS-1:0] l);
        t_out o;
        o.out_char    = ch;
        o.token_class = cls;
        o.token_start = start;
        o.line_number = line_out(l);
        o.error_code  = err;
        o.last_result = last;
        return o;
    endfunction

    assign o_in_ready  = (r_cnt <= QCNT_BITS'(2));
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_q[r_rp];
    assign out_acc     = o_out_valid && i_out_ready;

    // Lexing stage: up to three results per byte, filled into the result slots in order.
    always_comb begin
        t_idle      id;
        logic [7:0] c;
        logic       do_idle;
        id      = '0;
        id.mode = M_IDLE;
        c       = r_in.in_char;
        do_idle = 1'b0;
        n_mode  = r_mode;
        n_line  = r_line;
        n_res   = '0;
        for (int k = 0; k < MAX_RES; k++) begin
            slot[k] = '0;
        end

        if (c != CH_NUL) begin
            // A held slash that does not open a comment is lexed as an ordinary byte.
            if (n_mode == M_SLASH && c != CH_SLASH && c != CH_STAR) begin
                id = lex_idle(CH_SLASH, 1'b0, r_cfg);
                if (id.emit) begin
                    slot[n_res] = mk(id.ch, id.cls, id.start, id.err, 1'b0, n_line);
                    n_res       = n_res + 2'd1;
                end
                n_mode = id.mode;
            end
            unique case (n_mode)
                M_SLASH: begin
                    n_mode = (c == CH_SLASH) ? M_LCOMM : M_BLOCK;
                end
                M_LCOMM: begin
                    if (c == CH_NL) begin
                        n_line = line_inc(n_line);
                        n_mode = M_IDLE;
                    end
                end
                M_BLOCK, M_BSTAR: begin
                    if (c == CH_NL) begin
                        n_line = line_inc(n_line);
                        n_mode = M_BLOCK;
                    end else if (n_mode == M_BSTAR && c == CH_SLASH) begin
                        n_mode = M_IDLE;
                    end else begin
                        n_mode = (c == CH_STAR) ? M_BSTAR : M_BLOCK;
                    end
                end
                M_STRING: begin
                    if (c == CH_NL) begin
                        slot[n_res] = mk(CH_NUL, CLS_MARKER, 1'b0, ERR_STRING, 1'b0,
                                         n_line);
                        n_res       = n_res + 2'd1;
                        n_line      = line_inc(n_line);
                        n_mode      = M_IDLE;
                    end else begin
                        slot[n_res] = mk(c, CLS_STRING, 1'b0, ERR_NONE, 1'b0, n_line);
                        n_res       = n_res + 2'd1;
                        if (c == CH_QUOTE) begin
                            n_mode = M_IDLE;
                        end
                    end
                end
                M_WORD: begin
                    if (c > CH_SPACE) begin
                        slot[n_res] = mk(c, CLS_WORD, 1'b0, ERR_NONE, 1'b0, n_line);
                        n_res       = n_res + 2'd1;
                    end else begin
                        do_idle = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (is_digit(c) || c == CH_DOT) begin
                        slot[n_res] = mk(c, CLS_NUMBER, 1'b0, ERR_NONE, 1'b0, n_line);
                        n_res       = n_res + 2'd1;
                    end else begin
                        do_idle = 1'b1;
                    end
                end
                M_NAME: begin
                    if (is_name(c)) begin
                        slot[n_res] = mk(c, CLS_NAME, 1'b0, ERR_NONE, 1'b0, n_line);
                        n_res       = n_res + 2'd1;
                    end else begin
                        do_idle = 1'b1;
                    end
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase
            if (do_idle) begin
                id = lex_idle(c, 1'b1, r_cfg);
                if (id.emit) begin
                    slot[n_res] = mk(id.ch, id.cls, id.start, id.err, 1'b0, n_line);
                    n_res       = n_res + 2'd1;
                end
                if (id.nl) begin
                    n_line = line_inc(n_line);
                end
                n_mode = id.mode;
            end
        end

        if (c == CH_NUL || r_in.end_of_text) begin
            if (n_mode == M_SLASH) begin
                id = lex_idle(CH_SLASH, 1'b0, r_cfg);
                if (id.emit) begin
                    slot[n_res] = mk(id.ch, id.cls, id.start, id.err, 1'b0, n_line);
                    n_res       = n_res + 2'd1;
                end
                n_mode = id.mode;
            end
            if (n_mode == M_STRING) begin
                slot[n_res] = mk(CH_NUL, CLS_MARKER, 1'b0, ERR_STRING, 1'b0, n_line);
                n_res       = n_res + 2'd1;
            end
            // A byte yields at most three results; an end marker beyond them is dropped.
            if (n_res < 2'(MAX_RES)) begin
                slot[n_res] = mk(CH_NUL, CLS_MARKER, 1'b0, ERR_NONE, 1'b1, n_line);
                n_res       = n_res + 2'd1;
            end
            n_mode      = M_IDLE;
            n_line      = LINE_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= CFG_RESET;
            r_in_valid <= 1'b0;
            r_mode     <= M_IDLE;
            r_line     <= LINE_BITS'(1);
            r_wp       <= '0;
            r_rp       <= '0;
            r_cnt      <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx < CFG_IDX_BITS'(CFG_COUNT))) begin
                r_cfg[i_cfg_idx] <= i_cfg_data;
            end
            r_in_valid <= in_acc;
            if (r_in_valid) begin
                r_mode <= n_mode;
                r_line <= n_line;
                r_wp   <= r_wp + QPTR_BITS'(n_res);
            end
            if (out_acc) begin
                r_rp <= r_rp + QPTR_BITS'(1);
            end
            r_cnt <= r_cnt + (r_in_valid ? QCNT_BITS'(n_res) : QCNT_BITS'(0))
                   - (out_acc ? QCNT_BITS'(1) : QCNT_BITS'(0));
        end
    end

    // Input register and result queue payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (r_in_valid) begin
            for (int k = 0; k < MAX_RES; k++) begin
                if (2'(k) < n_res) begin
                    r_q[r_wp + QPTR_BITS'(k)] <= slot[k];
                end
            end
        end
    end

endmodule
